// File: hw/rtl/ccds_pkg.sv
// Shared constants, codes and control types of the closest clock divider search.
`timescale 1ns / 1ps

package ccds_pkg;

  // Data path width of rates and clock frequencies.
  localparam int DATA_W = 32;

  // Default divider limits.
  localparam int DEF_MAX_DIV_A     = 16;
  localparam int DEF_MAX_DIV_E     = 256;
  localparam int DEF_MAX_COUNT_DIV = 4096;

  // Configuration port.
  localparam int          ADDR_W           = 3;
  localparam int          REG_IDX_W        = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CORE_CLOCK = '0;
  localparam logic [DATA_W-1:0]    CORE_CLOCK_RESET = 32'd204000000;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_QA,
    ST_QA_WAIT,
    ST_QE,
    ST_QE_WAIT,
    ST_QC,
    ST_QC_WAIT,
    ST_EVAL,
    ST_OUT
  } ccds_state_t;

  // Which division the shared divider performs.
  typedef enum logic [1:0] {
    SEL_QA,
    SEL_QE,
    SEL_QC
  } ccds_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_start;
    ccds_sel_t div_sel;
    logic      set_high;
    logic      set_low;
    logic      init_search;
    logic      eval;
    logic      inc_a;
    logic      inc_e;
    logic      inc_c;
  } ccds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic ge_clock;
    logic le_lowest;
    logic hit;
    logic qc_below;
    logic a_last;
    logic e_last;
    logic c_last;
  } ccds_status_t;

endpackage

// File: hw/rtl/closest_clock_divider_search_top.sv
// Top level of the closest clock divider search.
`timescale 1ns / 1ps

// A request is taken when start is high while busy is low; its result is shown
// for exactly one cycle with done high, and the receiver cannot hold it off, so
// it must capture the result ports in that cycle. The lowest reachable rate
// comes from a multiplication by a constant reciprocal as the request is taken,
// so the classify state settles the edge cases and the output state shows them.
// The divisions by a, e and the counter run on one shared divider that yields
// one quotient bit per cycle. A real search adds one division for each value
// of a, one for each pair (a, e) and one plus a scoring step for each counter
// value tried. The counter loop stops at the first rate below the target
// and an exact match ends the search, so the count varies with the request.
// The clock register should only be written while busy is low.
module closest_clock_divider_search_top
  import ccds_pkg::*;
#(
  parameter int MAX_DIV_A     = DEF_MAX_DIV_A,
  parameter int MAX_DIV_E     = DEF_MAX_DIV_E,
  parameter int MAX_COUNT_DIV = DEF_MAX_COUNT_DIV
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] wanted_rate,
  output logic              done,
  output logic [4:0]        div_a,
  output logic [8:0]        div_e,
  output logic [12:0]       count_div,
  output logic [DATA_W-1:0] achieved_rate,
  output logic [DATA_W-1:0] rate_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] core_clock;
  ccds_cmd_t         cmd;
  ccds_status_t      status;

  ccds_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .core_clock (core_clock)
  );

  ccds_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ccds_datapath #(
    .MAX_DIV_A     (MAX_DIV_A),
    .MAX_DIV_E     (MAX_DIV_E),
    .MAX_COUNT_DIV (MAX_COUNT_DIV)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .core_clock    (core_clock),
    .wanted_rate   (wanted_rate),
    .div_a         (div_a),
    .div_e         (div_e),
    .count_div     (count_div),
    .achieved_rate (achieved_rate),
    .rate_error    (rate_error)
  );

endmodule

// File: hw/rtl/ccds_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ccds_divider
  import ccds_pkg::*;
#(
  parameter int DVSR_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DATA_W-1:0] rq;

  logic [DVSR_W:0]   shifted;
  logic              ge;
  logic [DVSR_W:0]   sub;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, rq[DATA_W-1]};
    ge      = shifted >= {1'b0, dvsr};
    sub     = shifted - {1'b0, dvsr};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and the shared dividend and quotient register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvsr <= divisor;
      rq   <= dividend;
    end else if (busy) begin
      rem <= ge ? sub[DVSR_W-1:0] : shifted[DVSR_W-1:0];
      rq  <= {rq[DATA_W-2:0], ge};
    end
  end

  assign quotient = rq;

endmodule

// File: hw/rtl/ccds_regs.sv
// Configuration register file with its APB-style port.
`timescale 1ns / 1ps

module ccds_regs
  import ccds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [DATA_W-1:0] core_clock
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // The source clock register.
  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock <= CORE_CLOCK_RESET;
    end else if (wr_en && paddr[ADDR_W-1:2] == REG_CORE_CLOCK) begin
      core_clock <= pwdata;
    end
  end

  // Read back; addresses beyond the register read as zero.
  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_CORE_CLOCK) begin
      prdata = core_clock;
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: hw/rtl/ccds_datapath.sv
// Datapath: loop counters, the shared divider, the best match and the result registers.
`timescale 1ns / 1ps

module ccds_datapath
  import ccds_pkg::*;
#(
  parameter int MAX_DIV_A     = DEF_MAX_DIV_A,
  parameter int MAX_DIV_E     = DEF_MAX_DIV_E,
  parameter int MAX_COUNT_DIV = DEF_MAX_COUNT_DIV
) (
  input  logic              clk,
  input  logic              rst,
  input  ccds_cmd_t         cmd,
  output ccds_status_t      status,
  input  logic [DATA_W-1:0] core_clock,
  input  logic [DATA_W-1:0] wanted_rate,
  output logic [4:0]        div_a,
  output logic [8:0]        div_e,
  output logic [12:0]       count_div,
  output logic [DATA_W-1:0] achieved_rate,
  output logic [DATA_W-1:0] rate_error
);

  localparam int AW = $clog2(MAX_DIV_A + 1);
  localparam int EW = $clog2(MAX_DIV_E + 1);
  localparam int CW = $clog2(MAX_COUNT_DIV + 1);
  localparam int AE_W   = (AW > EW) ? AW : EW;
  localparam int DVSR_W = (AE_W > CW) ? AE_W : CW;

  // The lowest reachable rate is the clock divided by the product of the three
  // limits. A product beyond the clock range always gives zero; otherwise the
  // division is a multiplication by a rounded-up reciprocal, exact for every
  // clock value.
  localparam logic [71:0] LOW_PROD  = 72'(MAX_DIV_A) * 72'(MAX_DIV_E) * 72'(MAX_COUNT_DIV);
  localparam bit          LOW_ZERO  = LOW_PROD > 72'(32'hFFFF_FFFF);
  localparam int          LOW_L     = LOW_ZERO ? 0 : $clog2(LOW_PROD);
  localparam int          LOW_SH    = DATA_W + LOW_L;
  localparam logic [71:0] LOW_RCP_W = ((72'd1 << LOW_SH) / LOW_PROD) + 72'd1;
  localparam int          PW        = 2 * DATA_W + 2;
  localparam logic [DATA_W+1:0] LOW_RCP = LOW_RCP_W[DATA_W+1:0];

  // Request and intermediate quotients.
  logic [DATA_W-1:0] wanted;
  logic [DATA_W-1:0] lowest;
  logic [DATA_W-1:0] qa;
  logic [DATA_W-1:0] qe;
  logic [DATA_W-1:0] qc;

  // Loop counters.
  logic [AW-1:0] a;
  logic [EW-1:0] e;
  logic [CW-1:0] c;

  // Best match so far.
  logic [AW-1:0]     best_a;
  logic [EW-1:0]     best_e;
  logic [CW-1:0]     best_c;
  logic [DATA_W-1:0] best_rate;
  logic [DATA_W-1:0] best_err;

  // Divider hookup.
  ccds_sel_t         sel;
  logic [DATA_W-1:0] dv_dividend;
  logic [DVSR_W-1:0] dv_divisor;
  logic              dv_done;
  logic [DATA_W-1:0] dv_quotient;

  logic [DATA_W-1:0] diff;
  logic              better;

  logic [PW-1:0]     low_prod;
  logic [DATA_W-1:0] low_rate;

  // Lowest reachable rate from the reciprocal product.
  always_comb begin
    low_prod = PW'(core_clock) * PW'(LOW_RCP);
    low_rate = LOW_ZERO ? '0 : DATA_W'(low_prod >> LOW_SH);
  end

  // Operand selection for the division being started.
  always_comb begin
    case (cmd.div_sel)
      SEL_QA: begin
        dv_dividend = core_clock;
        dv_divisor  = DVSR_W'(a);
      end
      SEL_QE: begin
        dv_dividend = qa;
        dv_divisor  = DVSR_W'(e);
      end
      SEL_QC: begin
        dv_dividend = qe;
        dv_divisor  = DVSR_W'(c);
      end
      default: begin
        dv_dividend = core_clock;
        dv_divisor  = DVSR_W'(1);
      end
    endcase
  end

  ccds_divider #(
    .DVSR_W (DVSR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quotient (dv_quotient)
  );

  // Remember where the running division's quotient belongs.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel <= cmd.div_sel;
    end
  end

  // Store a finished quotient.
  always_ff @(posedge clk) begin
    if (dv_done) begin
      case (sel)
        SEL_QA:  qa <= dv_quotient;
        SEL_QE:  qe <= dv_quotient;
        SEL_QC:  qc <= dv_quotient;
        default: qc <= dv_quotient;
      endcase
    end
  end

  // Distance of the current candidate and whether it beats the best.
  always_comb begin
    diff   = (qc > wanted) ? (qc - wanted) : (wanted - qc);
    better = diff < best_err;
  end

  // Latch the request and the lowest rate for the current clock.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wanted <= wanted_rate;
      lowest <= low_rate;
    end
  end

  // Loop counters for a, e and c.
  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      a <= AW'(1);
      e <= EW'(1);
      c <= CW'(1);
    end else if (cmd.inc_a) begin
      a <= a + 1'b1;
      e <= EW'(1);
      c <= CW'(1);
    end else if (cmd.inc_e) begin
      e <= e + 1'b1;
      c <= CW'(1);
    end else if (cmd.inc_c) begin
      c <= c + 1'b1;
    end
  end

  // Best match and result registers.
  always_ff @(posedge clk) begin
    if (cmd.set_high) begin
      best_a    <= AW'(1);
      best_e    <= EW'(1);
      best_c    <= CW'(1);
      best_rate <= core_clock;
      best_err  <= wanted - core_clock;
    end else if (cmd.set_low) begin
      best_a    <= AW'(MAX_DIV_A);
      best_e    <= EW'(MAX_DIV_E);
      best_c    <= CW'(MAX_COUNT_DIV);
      best_rate <= lowest;
      best_err  <= lowest - wanted;
    end else if (cmd.init_search) begin
      best_a    <= '0;
      best_e    <= '0;
      best_c    <= '0;
      best_rate <= '0;
      best_err  <= wanted;
    end else if (cmd.eval && better) begin
      best_a    <= a;
      best_e    <= e;
      best_c    <= c;
      best_rate <= qc;
      best_err  <= diff;
    end
  end

  // Status towards the controller.
  always_comb begin
    status.div_done  = dv_done;
    status.ge_clock  = wanted >= core_clock;
    status.le_lowest = wanted <= lowest;
    status.hit       = better && (diff == '0);
    status.qc_below  = qc < wanted;
    status.a_last    = a == AW'(MAX_DIV_A);
    status.e_last    = e == EW'(MAX_DIV_E);
    status.c_last    = c == CW'(MAX_COUNT_DIV);
  end

  // Result fields, fitted to their port widths.
  assign div_a         = 5'(best_a);
  assign div_e         = 9'(best_e);
  assign count_div     = 13'(best_c);
  assign achieved_rate = best_rate;
  assign rate_error    = best_err;

endmodule

// File: hw/rtl/ccds_ctrl.sv
// Controller state machine that sequences the divider search.
`timescale 1ns / 1ps

module ccds_ctrl
  import ccds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ccds_status_t status,
  output ccds_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  ccds_state_t state;
  ccds_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_QA;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      // Settle the two edge cases or start the search.
      ST_CLASSIFY: begin
        if (status.ge_clock) begin
          cmd.set_high = 1'b1;
          state_next   = ST_OUT;
        end else if (status.le_lowest) begin
          cmd.set_low = 1'b1;
          state_next  = ST_OUT;
        end else begin
          cmd.init_search = 1'b1;
          state_next      = ST_QA;
        end
      end
      ST_QA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_QA;
        state_next    = ST_QA_WAIT;
      end
      ST_QA_WAIT: begin
        if (status.div_done) state_next = ST_QE;
      end
      ST_QE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_QE;
        state_next    = ST_QE_WAIT;
      end
      ST_QE_WAIT: begin
        if (status.div_done) state_next = ST_QC;
      end
      ST_QC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_QC;
        state_next    = ST_QC_WAIT;
      end
      ST_QC_WAIT: begin
        if (status.div_done) state_next = ST_EVAL;
      end
      // Score the candidate and step the loops.
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.hit) begin
          state_next = ST_OUT;
        end else if (status.qc_below || status.c_last) begin
          if (status.e_last) begin
            if (status.a_last) begin
              state_next = ST_OUT;
            end else begin
              cmd.inc_a  = 1'b1;
              state_next = ST_QA;
            end
          end else begin
            cmd.inc_e  = 1'b1;
            state_next = ST_QE;
          end
        end else begin
          cmd.inc_c  = 1'b1;
          state_next = ST_QC;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_OUT;

endmodule

// File: hw/rtl/ccds_checker.sv
// Port-level checks of the request and result sequencing, bound to the top level.
`timescale 1ns / 1ps

module ccds_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted request makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result only appears while a request is in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe without a request in progress");

  // The result strobe lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // After the result the block is ready for the next request.
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after delivering a result");

endmodule

bind closest_clock_divider_search_top ccds_checker u_ccds_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
